FILE: hw/rtl/tmsf_pkg.sv
// ----------------------------------------------------------------------------
// tmsf_pkg: shared types and constants
// widths, register indexes and divider request/response for the filter
// ----------------------------------------------------------------------------
package tmsf_pkg;

    // fixed field widths
    localparam int CH_IN_W    = 3;
    localparam int SUM_W      = 16;
    localparam int CNT_W      = 4;
    localparam int ENTRY_W    = 15;
    localparam int GAIN_W     = 10;
    localparam int STEP_W     = 12;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 3;

    // shared divider operand widths
    localparam int DIV_DVD_W = SUM_W + GAIN_W;
    localparam int DIV_DVS_W = 7;
    localparam int DIV_CNT_W = $clog2(DIV_DVD_W);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_AVG_COUNT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERTICAL_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIAGONAL_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_STEP       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN_STEP     = 3'd4;

    // register reset values
    localparam logic [CNT_W-1:0]  AVG_COUNT_RST = 4'd5;
    localparam logic [GAIN_W-1:0] GAIN_RST      = 10'd100;
    localparam logic [STEP_W-1:0] UP_STEP_RST   = 12'd50;
    localparam logic [STEP_W-1:0] DOWN_STEP_RST = 12'd60;

    // scaled channel numbers
    localparam logic [CH_IN_W-1:0] CH_VERT_A = 3'd2;
    localparam logic [CH_IN_W-1:0] CH_VERT_B = 3'd3;
    localparam logic [CH_IN_W-1:0] CH_DIAG_A = 3'd4;
    localparam logic [CH_IN_W-1:0] CH_DIAG_B = 3'd5;

    // percent divisor, entry ceiling, output granularity
    localparam logic [DIV_DVS_W-1:0] GAIN_DEN  = 7'd100;
    localparam logic [ENTRY_W-1:0]   ENTRY_MAX = 15'h7fff;
    localparam logic [ENTRY_W-1:0]   TENS      = 15'd10;

    typedef struct packed {
        logic                 start;
        logic [DIV_DVD_W-1:0] dividend;
        logic [DIV_DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_DVD_W-1:0] quotient;
    } div_rsp_t;

endpackage

FILE: hw/rtl/tmsf_ram.sv
// ----------------------------------------------------------------------------
// tmsf_ram: generic single-write, single-read memory
// one write port, one read port, read data registered
// ----------------------------------------------------------------------------
module tmsf_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 30,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/tmsf_div.sv
// ----------------------------------------------------------------------------
// tmsf_div: shared restoring divider
// one quotient bit per cycle, done pulses once the quotient is complete
// ----------------------------------------------------------------------------
module tmsf_div (
    input  logic               clk,
    input  logic               rst_n,
    input  tmsf_pkg::div_req_t req,
    output tmsf_pkg::div_rsp_t rsp
);
    import tmsf_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_DVS_W-1:0] rem_reg, rem_next;
    logic [DIV_DVD_W-1:0] quo_reg, quo_next;
    logic [DIV_DVS_W-1:0] dvs_reg, dvs_next;
    logic [DIV_DVS_W:0]   shifted;
    logic [DIV_DVS_W:0]   diff;
    logic                 fits;

    assign shifted = {rem_reg, quo_reg[DIV_DVD_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign fits    = (shifted >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DIV_DVS_W-1:0] : shifted[DIV_DVS_W-1:0];
            quo_next = {quo_reg[DIV_DVD_W-2:0], fits};
            if (cnt_reg == DIV_CNT_W'(DIV_DVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

FILE: hw/rtl/trimmed_mean_sensor_filter.sv
// ----------------------------------------------------------------------------
// trimmed_mean_sensor_filter: olympic trimmed-mean filter with slew limit
// per-channel group average, percent gain, trimmed window mean, smoothing
// ----------------------------------------------------------------------------
// One request at a time. A request that does not close a group passes
// through S_IDLE and S_ACC (a channel number at or above NUM_CHANNELS is
// dropped in S_IDLE). Closing a group runs the average through the shared
// restoring divider, and on a gain channel the product goes through the
// divider a second time for the divide by 100. Closing a window adds the
// five-entry readout from the window memory (S_RD_ADDR then S_RD_DATA per
// entry), one more divider pass for the trim divide and the smoothing step,
// plus any wait for out_ready while an earlier result is still held. No
// clearing pass is needed after reset: window entries are always written
// before they are read.
// ----------------------------------------------------------------------------
module trimmed_mean_sensor_filter #(
    parameter int NUM_CHANNELS = 6,
    parameter int WINDOW_LEN   = 5,
    parameter int SAMPLE_BITS  = 12
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration writes
    input  logic                                cfg_we,
    input  logic [tmsf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tmsf_pkg::CFG_DATA_W-1:0]     cfg_data,
    // sample requests
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [tmsf_pkg::CH_IN_W-1:0]        channel,
    input  logic [SAMPLE_BITS-1:0]              sample,
    // result requests
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [tmsf_pkg::CH_IN_W-1:0]        out_channel,
    output logic [tmsf_pkg::ENTRY_W-1:0]        filtered_value,
    output logic [tmsf_pkg::ENTRY_W-1:0]        smoothed_value
);
    import tmsf_pkg::*;

    // channel index, window slot and window memory address widths
    localparam int CH_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int FILL_W   = $clog2(WINDOW_LEN);
    localparam int MEM_D    = NUM_CHANNELS * WINDOW_LEN;
    localparam int AW       = (MEM_D > 1) ? $clog2(MEM_D) : 1;
    // window sum and the trim divisor: drop two, average the rest, then tens
    localparam int WSUM_W   = ENTRY_W + $clog2(WINDOW_LEN);
    localparam int TRIM_DEN = (WINDOW_LEN - 2) * 10;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACC,
        S_DIV_AVG,
        S_DIV_GAIN,
        S_WRITE,
        S_RD_ADDR,
        S_RD_DATA,
        S_TRIM,
        S_DIV_MEAN,
        S_SMOOTH,
        S_EMIT
    } state_t;

    // configuration registers
    logic [CNT_W-1:0]  avg_count_reg;
    logic [GAIN_W-1:0] vertical_gain_reg;
    logic [GAIN_W-1:0] diagonal_gain_reg;
    logic [STEP_W-1:0] up_step_reg;
    logic [STEP_W-1:0] down_step_reg;

    // per-channel state
    logic [SUM_W-1:0]   sum_mem_reg  [NUM_CHANNELS];
    logic [CNT_W-1:0]   cnt_mem_reg  [NUM_CHANNELS];
    logic [FILL_W-1:0]  fill_mem_reg [NUM_CHANNELS];
    logic [ENTRY_W-1:0] sm_mem_reg   [NUM_CHANNELS];

    // sequencer
    state_t             state_reg, state_next;
    logic [CH_IN_W-1:0] ch_reg, ch_next;
    logic [CH_W-1:0]    ch_idx_reg, ch_idx_next;
    logic [SAMPLE_BITS-1:0] smp_reg, smp_next;
    logic [AW-1:0]      base_reg, base_next;
    logic [FILL_W-1:0]  k_reg, k_next;
    logic [ENTRY_W-1:0] entry_reg, entry_next;
    logic [WSUM_W-1:0]  acc_reg, acc_next;
    logic [ENTRY_W-1:0] lo_reg, lo_next;
    logic [ENTRY_W-1:0] hi_reg, hi_next;
    logic [ENTRY_W-1:0] filt_reg, filt_next;
    logic [ENTRY_W-1:0] smooth_reg, smooth_next;
    div_req_t           div_req_reg, div_req_next;
    div_rsp_t           div_rsp;
    logic               out_valid_reg, out_valid_next;
    logic [CH_IN_W-1:0] out_channel_reg, out_channel_next;
    logic [ENTRY_W-1:0] out_filt_reg, out_filt_next;
    logic [ENTRY_W-1:0] out_smooth_reg, out_smooth_next;

    // per-channel write controls
    logic               grp_we;
    logic [SUM_W-1:0]   grp_sum_wdata;
    logic [CNT_W-1:0]   grp_cnt_wdata;
    logic               fill_we;
    logic [FILL_W-1:0]  fill_wdata;
    logic               sm_we;

    // window memory ports
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    // datapath helpers
    logic               accept;
    logic [CNT_W-1:0]   n_eff;
    logic [SUM_W-1:0]   sum_new;
    logic [CNT_W-1:0]   cnt_new;
    logic               group_done;
    logic [FILL_W-1:0]  fill_cur;
    logic               is_vert;
    logic               is_diag;
    logic [GAIN_W-1:0]  gain_sel;
    logic [SUM_W-1:0]   avg;
    logic [DIV_DVD_W-1:0] prod;
    logic [WSUM_W-1:0]  trim_sum;
    logic [ENTRY_W-1:0] sm_old;
    logic [ENTRY_W-1:0] sm_calc;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);

    // configuration port, indexes beyond the list are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_count_reg     <= AVG_COUNT_RST;
            vertical_gain_reg <= GAIN_RST;
            diagonal_gain_reg <= GAIN_RST;
            up_step_reg       <= UP_STEP_RST;
            down_step_reg     <= DOWN_STEP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_AVG_COUNT:     avg_count_reg     <= cfg_data[CNT_W-1:0];
                CFG_VERTICAL_GAIN: vertical_gain_reg <= cfg_data[GAIN_W-1:0];
                CFG_DIAGONAL_GAIN: diagonal_gain_reg <= cfg_data[GAIN_W-1:0];
                CFG_UP_STEP:       up_step_reg       <= cfg_data[STEP_W-1:0];
                CFG_DOWN_STEP:     down_step_reg     <= cfg_data[STEP_W-1:0];
                default:           ;
            endcase
        end
    end

    // group accumulate; a zero count acts as one, and a count lowered
    // mid-group closes the group at once
    assign n_eff      = (avg_count_reg == '0) ? CNT_W'(1) : avg_count_reg;
    assign sum_new    = sum_mem_reg[ch_idx_reg] + SUM_W'(smp_reg);
    assign cnt_new    = cnt_mem_reg[ch_idx_reg] + CNT_W'(1);
    assign group_done = (cnt_new >= n_eff);

    // window slot; a full count wraps to the first slot
    assign fill_cur = (32'(fill_mem_reg[ch_idx_reg]) >= WINDOW_LEN) ? '0
                    : fill_mem_reg[ch_idx_reg];

    // gain select: vertical pair, diagonal pair, the rest unscaled
    assign is_vert  = (ch_reg == CH_VERT_A) || (ch_reg == CH_VERT_B);
    assign is_diag  = (ch_reg == CH_DIAG_A) || (ch_reg == CH_DIAG_B);
    assign gain_sel = is_vert ? vertical_gain_reg : diagonal_gain_reg;
    assign avg      = div_rsp.quotient[SUM_W-1:0];
    assign prod     = avg * gain_sel;

    // sum of the middle entries
    assign trim_sum = acc_reg - WSUM_W'(lo_reg) - WSUM_W'(hi_reg);

    // slew limit; a step is taken only when it falls short of the target, so no wrap
    assign sm_old = sm_mem_reg[ch_idx_reg];
    always_comb
    begin
        if (filt_reg >= sm_old)
        begin
            sm_calc = ((filt_reg - sm_old) > ENTRY_W'(up_step_reg))
                    ? sm_old + ENTRY_W'(up_step_reg) : filt_reg;
        end
        else
        begin
            sm_calc = ((sm_old - filt_reg) > ENTRY_W'(down_step_reg))
                    ? sm_old - ENTRY_W'(down_step_reg) : filt_reg;
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next       = state_reg;
        ch_next          = ch_reg;
        ch_idx_next      = ch_idx_reg;
        smp_next         = smp_reg;
        base_next        = base_reg;
        k_next           = k_reg;
        entry_next       = entry_reg;
        acc_next         = acc_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        filt_next        = filt_reg;
        smooth_next      = smooth_reg;
        div_req_next     = div_req_reg;
        div_req_next.start = 1'b0;
        out_valid_next   = out_valid_reg && !out_ready;
        out_channel_next = out_channel_reg;
        out_filt_next    = out_filt_reg;
        out_smooth_next  = out_smooth_reg;

        grp_we        = 1'b0;
        grp_sum_wdata = sum_new;
        grp_cnt_wdata = cnt_new;
        fill_we       = 1'b0;
        fill_wdata    = fill_cur + FILL_W'(1);
        sm_we         = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = base_reg + AW'(fill_cur);
        ram_re        = 1'b0;
        ram_raddr     = base_reg + AW'(k_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ch_next     = channel;
                    ch_idx_next = CH_W'(channel);
                    smp_next    = sample;
                    // channels past the last one are dropped
                    if (32'(channel) < NUM_CHANNELS)
                    begin
                        state_next = S_ACC;
                    end
                end
            end

            S_ACC:
            begin
                grp_we    = 1'b1;
                base_next = AW'(ch_idx_reg * WINDOW_LEN);
                if (group_done)
                begin
                    grp_sum_wdata         = '0;
                    grp_cnt_wdata         = '0;
                    div_req_next.start    = 1'b1;
                    div_req_next.dividend = DIV_DVD_W'(sum_new);
                    div_req_next.divisor  = DIV_DVS_W'(n_eff);
                    state_next            = S_DIV_AVG;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_DIV_AVG:
            begin
                if (div_rsp.done)
                begin
                    if (is_vert || is_diag)
                    begin
                        // product goes straight into the divider operand
                        div_req_next.start    = 1'b1;
                        div_req_next.dividend = prod;
                        div_req_next.divisor  = GAIN_DEN;
                        state_next            = S_DIV_GAIN;
                    end
                    else
                    begin
                        entry_next = (avg > SUM_W'(ENTRY_MAX)) ? ENTRY_MAX
                                   : avg[ENTRY_W-1:0];
                        state_next = S_WRITE;
                    end
                end
            end

            S_DIV_GAIN:
            begin
                if (div_rsp.done)
                begin
                    entry_next = (div_rsp.quotient > DIV_DVD_W'(ENTRY_MAX)) ? ENTRY_MAX
                               : div_rsp.quotient[ENTRY_W-1:0];
                    state_next = S_WRITE;
                end
            end

            S_WRITE:
            begin
                ram_we  = 1'b1;
                fill_we = 1'b1;
                if (fill_cur == FILL_W'(WINDOW_LEN - 1))
                begin
                    fill_wdata = '0;
                    k_next     = '0;
                    acc_next   = '0;
                    state_next = S_RD_ADDR;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_RD_ADDR:
            begin
                ram_re     = 1'b1;
                state_next = S_RD_DATA;
            end

            S_RD_DATA:
            begin
                acc_next = acc_reg + WSUM_W'(ram_rdata);
                if (k_reg == '0)
                begin
                    lo_next = ram_rdata;
                    hi_next = ram_rdata;
                end
                else
                begin
                    lo_next = (ram_rdata < lo_reg) ? ram_rdata : lo_reg;
                    hi_next = (ram_rdata > hi_reg) ? ram_rdata : hi_reg;
                end
                if (k_reg == FILL_W'(WINDOW_LEN - 1))
                begin
                    state_next = S_TRIM;
                end
                else
                begin
                    k_next     = k_reg + FILL_W'(1);
                    state_next = S_RD_ADDR;
                end
            end

            S_TRIM:
            begin
                div_req_next.start    = 1'b1;
                div_req_next.dividend = DIV_DVD_W'(trim_sum);
                div_req_next.divisor  = DIV_DVS_W'(TRIM_DEN);
                state_next            = S_DIV_MEAN;
            end

            S_DIV_MEAN:
            begin
                if (div_rsp.done)
                begin
                    // quotient is the mean in tens
                    filt_next  = div_rsp.quotient[ENTRY_W-1:0] * TENS;
                    state_next = S_SMOOTH;
                end
            end

            S_SMOOTH:
            begin
                sm_we       = 1'b1;
                smooth_next = sm_calc;
                state_next  = S_EMIT;
            end

            S_EMIT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    out_channel_next = ch_reg;
                    out_filt_next    = filt_reg;
                    out_smooth_next  = smooth_reg;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // sequencer state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            div_req_reg       <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            div_req_reg       <= div_req_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // working registers, no reset needed
    always_ff @(posedge clk)
    begin
        ch_reg               <= ch_next;
        ch_idx_reg           <= ch_idx_next;
        smp_reg              <= smp_next;
        base_reg             <= base_next;
        k_reg                <= k_next;
        entry_reg            <= entry_next;
        acc_reg              <= acc_next;
        lo_reg               <= lo_next;
        hi_reg               <= hi_next;
        filt_reg             <= filt_next;
        smooth_reg           <= smooth_next;
        out_channel_reg      <= out_channel_next;
        out_filt_reg         <= out_filt_next;
        out_smooth_reg       <= out_smooth_next;
    end

    // per-channel state, all cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                sum_mem_reg[i]  <= '0;
                cnt_mem_reg[i]  <= '0;
                fill_mem_reg[i] <= '0;
                sm_mem_reg[i]   <= '0;
            end
        end
        else
        begin
            if (grp_we)
            begin
                sum_mem_reg[ch_idx_reg] <= grp_sum_wdata;
                cnt_mem_reg[ch_idx_reg] <= grp_cnt_wdata;
            end
            if (fill_we)
            begin
                fill_mem_reg[ch_idx_reg] <= fill_wdata;
            end
            if (sm_we)
            begin
                sm_mem_reg[ch_idx_reg] <= sm_calc;
            end
        end
    end

    // window entries, one row of WINDOW_LEN per channel
    tmsf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MEM_D)
    ) u_window_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (entry_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // shared divider: group average, percent gain, trimmed mean
    tmsf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req_reg),
        .rsp   (div_rsp)
    );

    assign out_valid      = out_valid_reg;
    assign out_channel    = out_channel_reg;
    assign filtered_value = out_filt_reg;
    assign smoothed_value = out_smooth_reg;

endmodule

FILE: verif/trimmed_mean_sensor_filter_test.sv
// ----------------------------------------------------------------------------
// trimmed_mean_sensor_filter_test: self-checking bench for the sensor filter
// directed table of extreme samples, then randomized phases over the gain,
// count and slew settings, each result checked against typed values or a local filter model
// ----------------------------------------------------------------------------
module trimmed_mean_sensor_filter_test;

    import tmsf_pkg::*;

    localparam int NUM_CH       = 6;
    localparam int WINDOW_LEN   = 5;
    localparam int SAMPLE_BITS  = 12;
    localparam int TRIM_KEEP    = 3;        // entries left after dropping min and max
    localparam int NUM_PHASES   = 6;
    localparam int DIRECTED_LEN = 22;
    localparam int SETTLE_CYCLES = 200;     // margin after the last result for the tail of the last request
    localparam int LONG_HOLD    = 2000;     // result side back-pressure stretch
    localparam int TIMEOUT_TIME = 4_000_000;

    // how a stimulus row is checked
    typedef enum logic [1:0] {
        BY_MODEL,
        NO_RESULT,
        TYPED
    } check_t;

    typedef struct packed {
        logic [CH_IN_W-1:0] chan;
        logic [ENTRY_W-1:0] filt;
        logic [ENTRY_W-1:0] smooth;
    } window_result_t;

    typedef struct packed {
        check_t                 check;
        logic [CH_IN_W-1:0]     chan;
        logic [SAMPLE_BITS-1:0] smp;
        logic [ENTRY_W-1:0]     filt;
        logic [ENTRY_W-1:0]     smooth;
    } directed_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic [CH_IN_W-1:0]     channel;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   out_valid;
    logic                   out_ready;
    logic [CH_IN_W-1:0]     out_channel;
    logic [ENTRY_W-1:0]     filtered_value;
    logic [ENTRY_W-1:0]     smoothed_value;

    // model copy of the registers
    logic [CNT_W-1:0]  avg_count_q;
    logic [GAIN_W-1:0] vertical_gain_q;
    logic [GAIN_W-1:0] diagonal_gain_q;
    logic [STEP_W-1:0] up_step_q;
    logic [STEP_W-1:0] down_step_q;

    // model copy of the per-channel state
    logic [SUM_W-1:0]   group_sum      [NUM_CH];
    logic [CNT_W-1:0]   group_count    [NUM_CH];
    logic [2:0]         window_fill    [NUM_CH];
    logic [ENTRY_W-1:0] window_store   [NUM_CH][WINDOW_LEN];
    logic [ENTRY_W-1:0] smoothed_store [NUM_CH];

    window_result_t expected_windows[$];
    int             mismatch_count = 0;
    bit             idle_on;
    bit             long_hold_req = 1'b0;

    trimmed_mean_sensor_filter #(
        .NUM_CHANNELS (NUM_CH),
        .WINDOW_LEN   (WINDOW_LEN),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .channel        (channel),
        .sample         (sample),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_channel    (out_channel),
        .filtered_value (filtered_value),
        .smoothed_value (smoothed_value)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // hard stop in case the block hangs
    initial
    begin
        #(TIMEOUT_TIME);
        $display("trimmed_mean_sensor_filter_test: done, errors");
        $finish;
    end

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("mismatch: %s got %0d want %0d", what, got, want);
        mismatch_count++;
    endtask

    // one accepted sample through the filter model; hit is set when it closes a window
    task automatic filter_sample(input logic [CH_IN_W-1:0] ch,
                                 input logic [SAMPLE_BITS-1:0] smp,
                                 output bit hit, output window_result_t res);
        int unsigned n, avg, gain, entry, total, lo, hi, filt, old, sm;
        bit scaled;
        hit = 1'b0;
        res = '0;
        // channels past the last one are dropped without touching state
        if (ch < NUM_CH)
        begin
            // a zero count behaves as one
            n = (avg_count_q == 0) ? 1 : avg_count_q;
            group_sum[ch] = group_sum[ch] + smp;
            group_count[ch] = group_count[ch] + 1'b1;
            // >= so a count lowered mid-group closes the group at once
            if (group_count[ch] >= n)
            begin
                avg = group_sum[ch] / n;
                group_sum[ch] = '0;
                group_count[ch] = '0;
                scaled = 1'b1;
                gain = 0;
                if (ch == CH_VERT_A || ch == CH_VERT_B)
                    gain = vertical_gain_q;
                else if (ch == CH_DIAG_A || ch == CH_DIAG_B)
                    gain = diagonal_gain_q;
                else
                    scaled = 1'b0;
                entry = scaled ? avg * gain / GAIN_DEN : avg;
                if (entry > ENTRY_MAX)
                    entry = ENTRY_MAX;
                if (window_fill[ch] >= WINDOW_LEN)
                    window_fill[ch] = '0;
                window_store[ch][window_fill[ch]] = ENTRY_W'(entry);
                window_fill[ch] = window_fill[ch] + 1'b1;
                if (window_fill[ch] >= WINDOW_LEN)
                begin
                    window_fill[ch] = '0;
                    total = 0;
                    lo = window_store[ch][0];
                    hi = lo;
                    for (int i = 0; i < WINDOW_LEN; i++)
                    begin
                        total += window_store[ch][i];
                        if (window_store[ch][i] < lo)
                            lo = window_store[ch][i];
                        if (window_store[ch][i] > hi)
                            hi = window_store[ch][i];
                    end
                    filt = (total - lo - hi) / TRIM_KEEP / TENS * TENS;
                    // slew limit against the last smoothed value
                    old = smoothed_store[ch];
                    if (filt >= old)
                        sm = (filt - old > up_step_q) ? old + up_step_q : filt;
                    else
                        sm = (old - filt > down_step_q) ? old - down_step_q : filt;
                    smoothed_store[ch] = ENTRY_W'(sm);
                    hit = 1'b1;
                    res.chan = ch;
                    res.filt = ENTRY_W'(filt);
                    res.smooth = smoothed_store[ch];
                end
            end
        end
    endtask

    // program all five registers, one write per cycle, block idle
    task automatic apply_settings(input int unsigned avg, input int unsigned vgain,
                                  input int unsigned dgain, input int unsigned up,
                                  input int unsigned down);
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] value;
        for (reg_idx = CFG_AVG_COUNT; reg_idx <= CFG_DOWN_STEP; reg_idx++)
        begin
            case (reg_idx)
                CFG_AVG_COUNT:
                begin
                    value = CFG_DATA_W'(avg);
                    avg_count_q = value[CNT_W-1:0];
                end
                CFG_VERTICAL_GAIN:
                begin
                    value = CFG_DATA_W'(vgain);
                    vertical_gain_q = value[GAIN_W-1:0];
                end
                CFG_DIAGONAL_GAIN:
                begin
                    value = CFG_DATA_W'(dgain);
                    diagonal_gain_q = value[GAIN_W-1:0];
                end
                CFG_UP_STEP:
                begin
                    value = CFG_DATA_W'(up);
                    up_step_q = value[STEP_W-1:0];
                end
                default:
                begin
                    value = CFG_DATA_W'(down);
                    down_step_q = value[STEP_W-1:0];
                end
            endcase
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= reg_idx;
            cfg_data  <= value;
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // offer one sample request, wait for the handshake, then predict
    task automatic send_sample(input logic [CH_IN_W-1:0] ch,
                               input logic [SAMPLE_BITS-1:0] smp,
                               input check_t check,
                               input logic [ENTRY_W-1:0] filt,
                               input logic [ENTRY_W-1:0] smooth);
        window_result_t predicted;
        bit             hit;
        // random idle burst before the request
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(0, 14)) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        channel  <= ch;
        sample   <= smp;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        filter_sample(ch, smp, hit, predicted);
        case (check)
            BY_MODEL:
                if (hit)
                    expected_windows.push_back(predicted);
            TYPED:
                expected_windows.push_back({ch, filt, smooth});
            default:
                ;
        endcase
    endtask

    // drop valid, wait out every result and the tail of the last request
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_windows.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // directed rows, run with one sample per entry, vertical gain at its
    // ceiling (saturates) and diagonal gain zero
    function automatic directed_row_t directed_row(input int idx);
        case (idx)
            0:  return '{NO_RESULT, 3'd0, 12'd4095, 15'd0,     15'd0};
            1:  return '{NO_RESULT, 3'd2, 12'd4095, 15'd0,     15'd0};
            2:  return '{NO_RESULT, 3'd4, 12'd4095, 15'd0,     15'd0};
            3:  return '{NO_RESULT, 3'd6, 12'd4095, 15'd0,     15'd0};  // dropped channel
            4:  return '{NO_RESULT, 3'd0, 12'd4095, 15'd0,     15'd0};
            5:  return '{NO_RESULT, 3'd2, 12'd4095, 15'd0,     15'd0};
            6:  return '{NO_RESULT, 3'd4, 12'd4095, 15'd0,     15'd0};
            7:  return '{BY_MODEL,  3'd1, 12'd0,    15'd0,     15'd0};
            8:  return '{NO_RESULT, 3'd0, 12'd4095, 15'd0,     15'd0};
            9:  return '{NO_RESULT, 3'd2, 12'd4095, 15'd0,     15'd0};
            10: return '{NO_RESULT, 3'd4, 12'd4095, 15'd0,     15'd0};
            11: return '{NO_RESULT, 3'd7, 12'd0,    15'd0,     15'd0};  // dropped channel
            12: return '{BY_MODEL,  3'd1, 12'd2048, 15'd0,     15'd0};
            13: return '{NO_RESULT, 3'd0, 12'd4095, 15'd0,     15'd0};
            14: return '{NO_RESULT, 3'd2, 12'd4095, 15'd0,     15'd0};
            15: return '{NO_RESULT, 3'd4, 12'd4095, 15'd0,     15'd0};
            16: return '{BY_MODEL,  3'd1, 12'd4095, 15'd0,     15'd0};
            // full scale, rise limited to the reset up step
            17: return '{TYPED,     3'd0, 12'd4095, 15'd4090,  15'd50};
            // gain product saturates at the entry ceiling
            18: return '{TYPED,     3'd2, 12'd4095, 15'd32760, 15'd50};
            // zero gain wipes the entries
            19: return '{TYPED,     3'd4, 12'd4095, 15'd0,     15'd0};
            20: return '{BY_MODEL,  3'd1, 12'd1,    15'd0,     15'd0};
            default: return '{BY_MODEL, 3'd1, 12'd4094, 15'd0, 15'd0};
        endcase
    endfunction

    // result side: ready with random stall bursts and one long hold-off
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (long_hold_req)
            begin
                // block fills with one held result and then stalls its input
                long_hold_req = 1'b0;
                stall_left = LONG_HOLD - 1;
                out_ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(0, 14);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // compare every accepted result with the oldest prediction
    always @(posedge clk)
    begin : result_check
        window_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_windows.size() == 0)
                flag_mismatch("result with nothing pending, out_channel", out_channel, -1);
            else
            begin
                want = expected_windows.pop_front();
                if (out_channel !== want.chan)
                    flag_mismatch("out_channel", out_channel, want.chan);
                if (filtered_value !== want.filt)
                    flag_mismatch("filtered_value", filtered_value, want.filt);
                if (smoothed_value !== want.smooth)
                    flag_mismatch("smoothed_value", smoothed_value, want.smooth);
            end
        end
    end

    initial
    begin : stimulus
        directed_row_t      row;
        int unsigned        p_avg, p_vgain, p_dgain, p_up, p_down, p_items;
        int unsigned        accepted, focus_ch, pick;
        int                 lvl;
        int                 level [8];
        logic [CH_IN_W-1:0]     ch;
        logic [SAMPLE_BITS-1:0] smp;

        // every input known from time zero, reset held
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        channel   = '0;
        sample    = '0;
        idle_on   = 1'b1;

        // model matches the block's reset state
        avg_count_q     = AVG_COUNT_RST;
        vertical_gain_q = GAIN_RST;
        diagonal_gain_q = GAIN_RST;
        up_step_q       = UP_STEP_RST;
        down_step_q     = DOWN_STEP_RST;
        for (int c = 0; c < NUM_CH; c++)
        begin
            group_sum[c]      = '0;
            group_count[c]    = '0;
            window_fill[c]    = '0;
            smoothed_store[c] = '0;
            for (int w = 0; w < WINDOW_LEN; w++)
                window_store[c][w] = '0;
        end
        for (int c = 0; c < 8; c++)
            level[c] = int'($urandom_range(0, 4095));

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // directed part
        apply_settings(1, 1023, 0, UP_STEP_RST, DOWN_STEP_RST);
        for (int i = 0; i < DIRECTED_LEN; i++)
        begin
            row = directed_row(i);
            send_sample(row.chan, row.smp, row.check, row.filt, row.smooth);
        end

        // random phases, each with its own register setting
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            settle();
            case (phase)
                0:       {p_avg, p_vgain, p_dgain, p_up, p_down, p_items} =
                             {32'd1,  32'd800,  32'd0,    32'd4095, 32'd0,    32'd300};
                1:       {p_avg, p_vgain, p_dgain, p_up, p_down, p_items} =
                             {32'd0,  32'd0,    32'd800,  32'd0,    32'd4095, 32'd300};
                2:       {p_avg, p_vgain, p_dgain, p_up, p_down, p_items} =
                             {32'd15, 32'd333,  32'd99,   32'd50,   32'd60,   32'd200};
                3:       {p_avg, p_vgain, p_dgain, p_up, p_down, p_items} =
                             {32'd3,  32'd1023, 32'd1023, 32'd1,    32'd4095, 32'd300};
                4:       {p_avg, p_vgain, p_dgain, p_up, p_down, p_items} =
                             {32'd2,  32'd100,  32'd555,  32'd4095, 32'd1,    32'd300};
                default: {p_avg, p_vgain, p_dgain, p_up, p_down, p_items} =
                             {32'd4,  32'd150,  32'd75,   32'd200,  32'd300,  32'd200};
            endcase
            // moving from 15 down to 3 leaves groups already past the new count
            apply_settings(p_avg, p_vgain, p_dgain, p_up, p_down);
            // short groups in the first phase, so results pile up under the hold-off
            if (phase == 0)
                long_hold_req = 1'b1;
            focus_ch = $urandom_range(0, NUM_CH - 1);
            accepted = 0;
            while (accepted < p_items)
            begin
                // stretches with and without idling, none in the final phase
                if (accepted % 40 == 0)
                    idle_on = (phase != NUM_PHASES - 1) && ($urandom_range(0, 2) != 0);
                // mostly one channel when groups are long, so windows still close
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    ch = CH_IN_W'($urandom_range(NUM_CH, 7));
                else if (pick <= ((p_avg >= 8) ? 8 : 5))
                    ch = CH_IN_W'(focus_ch);
                else
                    ch = CH_IN_W'($urandom_range(0, NUM_CH - 1));
                // extremes, raw noise, or a drifting level for the slew limiter
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    smp = '0;
                else if (pick == 1)
                    smp = '1;
                else if (pick <= 4)
                    smp = SAMPLE_BITS'($urandom);
                else
                begin
                    if (pick == 9)
                        level[ch] = int'($urandom_range(0, 4095));
                    lvl = level[ch] + int'($urandom_range(0, 400)) - 200;
                    if (lvl < 0)
                        lvl = 0;
                    if (lvl > 4095)
                        lvl = 4095;
                    level[ch] = lvl;
                    smp = SAMPLE_BITS'(lvl);
                end
                send_sample(ch, smp, BY_MODEL, '0, '0);
                if (ch < NUM_CH)
                    accepted++;
            end
        end

        settle();
        if (mismatch_count == 0)
            $display("trimmed_mean_sensor_filter_test: done, clean");
        else
            $display("trimmed_mean_sensor_filter_test: done, errors");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/tmsf_pkg.sv
hw/rtl/tmsf_ram.sv
hw/rtl/tmsf_div.sv
hw/rtl/trimmed_mean_sensor_filter.sv
verif/trimmed_mean_sensor_filter_test.sv
